@@ sv/assert_macros.svh @@
// Shared assertion macros for the residual reducer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication: cons must hold the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/npr_pkg.sv @@
package npr_pkg;

  localparam int NPR_COORD_W = 24;
  localparam int NPR_VAL_W   = 32;
  localparam int NPR_VOLT_W  = 31;
  localparam int NPR_RAD_W   = 64;
  localparam int NPR_ROOT_W  = 32;
  localparam int NPR_SPH_W   = 2 * NPR_COORD_W + 1;

  // Queue depth between front and back; keep a power of two.
  localparam int NPR_QDEPTH  = 2;
  localparam int NPR_QPTR_W  = $clog2(NPR_QDEPTH);
  localparam int NPR_QCNT_W  = $clog2(NPR_QDEPTH + 1);

  localparam logic [NPR_COORD_W-1:0] NPR_RST_GROUND_HEIGHT = 24'd0;
  localparam logic [NPR_COORD_W-1:0] NPR_RST_GROUND_DEPTH  = 24'd1000;
  localparam logic [NPR_COORD_W-1:0] NPR_RST_TIP_HEIGHT    = 24'd100000;
  localparam logic [NPR_COORD_W-1:0] NPR_RST_TIP_RADIUS    = 24'd5000;
  localparam logic [NPR_COORD_W-1:0] NPR_RST_SHANK_RADIUS  = 24'd5000;

  typedef enum logic [2:0] {
    REG_GROUND_HEIGHT   = 3'd0,
    REG_GROUND_DEPTH    = 3'd1,
    REG_TIP_HEIGHT      = 3'd2,
    REG_TIP_RADIUS      = 3'd3,
    REG_SHANK_RADIUS    = 3'd4,
    REG_APPLIED_VOLTAGE = 3'd5
  } npr_reg_e;

  typedef enum logic [1:0] {
    CLASS_GAS    = 2'd0,
    CLASS_GROUND = 2'd1,
    CLASS_HV     = 2'd2
  } npr_class_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_SQ_R,
    F_SQ_DZ,
    F_SQ_TR,
    F_SQ_ER,
    F_SQ_EZ,
    F_SUM,
    F_ROOT_GO,
    F_ROOT_WAIT,
    F_PUSH
  } npr_fstate_e;

  typedef struct packed {
    logic        [NPR_COORD_W-1:0] ground_height;
    logic        [NPR_COORD_W-1:0] ground_depth;
    logic        [NPR_COORD_W-1:0] tip_height;
    logic        [NPR_COORD_W-1:0] tip_radius;
    logic        [NPR_COORD_W-1:0] shank_radius;
    logic signed [NPR_VOLT_W-1:0]  applied_voltage;
  } npr_cfg_t;

  typedef struct packed {
    logic        [NPR_COORD_W-1:0] radius;
    logic        [NPR_COORD_W-1:0] height;
    logic signed [NPR_VAL_W-1:0]   potential;
    logic signed [NPR_VAL_W-1:0]   radial_field;
    logic signed [NPR_VAL_W-1:0]   axial_field;
    logic                          last_cell;
  } npr_in_t;

  typedef struct packed {
    logic [1:0]           cell_class;
    logic [NPR_VAL_W-1:0] peak_field;
    logic [NPR_VAL_W-1:0] peak_hv_error;
    logic [NPR_VAL_W-1:0] peak_ground_error;
    logic                 sweep_done;
  } npr_out_t;

  // One classified cell handed from front to back.
  typedef struct packed {
    npr_class_e            cls;
    logic [NPR_ROOT_W-1:0] mag;
    logic [NPR_VAL_W-1:0]  hv_err;
    logic [NPR_VAL_W-1:0]  gnd_err;
    logic                  last;
  } npr_task_t;

  function automatic logic [NPR_VAL_W-1:0] npr_abs32(input logic signed [NPR_VAL_W-1:0] x);
    npr_abs32 = x[NPR_VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ sv/npr_isqrt.sv @@
`include "assert_macros.svh"

module npr_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [npr_pkg::NPR_RAD_W-1:0]  radicand,
  output logic                           busy,
  output logic [npr_pkg::NPR_ROOT_W-1:0] root
);
  import npr_pkg::*;

  localparam int CNT_W = $clog2(NPR_ROOT_W);
  localparam int REM_W = NPR_ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic [NPR_RAD_W-1:0] rad;
  logic [REM_W-1:0]     rem;
  logic [CNT_W-1:0]     cnt;
  logic [SH_W-1:0]      rem_sh;
  logic [SH_W-1:0]      trial;
  logic                 take;

  // Restoring square root, one result bit per cycle, MSB first.
  assign rem_sh = {rem, rad[NPR_RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NPR_ROOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[NPR_RAD_W-3:0], 2'b00};
      if (take) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[NPR_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[NPR_ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/npr_queue.sv @@
`include "assert_macros.svh"

module npr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  npr_pkg::npr_task_t  push_task,
  output logic                full,
  input  logic                pop,
  output npr_pkg::npr_task_t  pop_task,
  output logic                empty
);
  import npr_pkg::*;

  npr_task_t             slots [NPR_QDEPTH];
  logic [NPR_QPTR_W-1:0] wr_ptr;
  logic [NPR_QPTR_W-1:0] rd_ptr;
  logic [NPR_QCNT_W-1:0] count;

  assign full     = count == NPR_QCNT_W'(NPR_QDEPTH);
  assign empty    = count == '0;
  assign pop_task = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_task;
    end
  end

  `ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, pop, !empty)

endmodule

@@ sv/npr_front.sv @@
`include "assert_macros.svh"

module npr_front (
  input  logic               clk,
  input  logic               rst,
  input  npr_pkg::npr_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  npr_pkg::npr_in_t   in_word,
  input  logic               q_full,
  output logic               q_push,
  output npr_pkg::npr_task_t q_task
);
  import npr_pkg::*;

  npr_fstate_e state;
  npr_fstate_e state_next;

  logic [NPR_COORD_W-1:0] r;
  logic [NPR_COORD_W-1:0] dz;
  logic                   below_top;
  logic                   in_shank;
  logic [NPR_VAL_W-1:0]   er;
  logic [NPR_VAL_W-1:0]   ez;
  logic [NPR_VAL_W-1:0]   hv_err;
  logic [NPR_VAL_W-1:0]   gnd_err;
  logic                   last;
  npr_class_e             cls;

  logic [NPR_RAD_W-1:0]   prod;
  logic [NPR_SPH_W-1:0]   sph;
  logic [NPR_RAD_W-1:0]   fsq;
  logic [NPR_ROOT_W-1:0]  mag;

  logic [NPR_VAL_W-1:0]   mul_a;
  logic [NPR_VAL_W-1:0]   mul_b;
  logic                   sq_start;
  logic                   sq_busy;
  logic [NPR_ROOT_W-1:0]  sq_root;
  logic                   accept;

  logic [NPR_COORD_W:0]   ground_top;
  logic signed [NPR_VAL_W:0] hv_diff;
  logic [NPR_VAL_W:0]     hv_abs;

  assign accept     = in_valid && !in_stall;
  assign ground_top = {1'b0, cfg.ground_height} + {1'b0, cfg.ground_depth};
  assign hv_diff    = {in_word.potential[NPR_VAL_W-1], in_word.potential}
                    - {{2{cfg.applied_voltage[NPR_VOLT_W-1]}}, cfg.applied_voltage};
  assign hv_abs     = hv_diff[NPR_VAL_W] ? (~hv_diff + 1'b1) : hv_diff;

  npr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (fsq),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    sq_start   = 1'b0;
    q_push     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = F_SQ_R;
        end
      end
      F_SQ_R: begin
        mul_a      = NPR_VAL_W'(r);
        mul_b      = NPR_VAL_W'(r);
        state_next = F_SQ_DZ;
      end
      F_SQ_DZ: begin
        mul_a      = NPR_VAL_W'(dz);
        mul_b      = NPR_VAL_W'(dz);
        state_next = F_SQ_TR;
      end
      F_SQ_TR: begin
        mul_a      = NPR_VAL_W'(cfg.tip_radius);
        mul_b      = NPR_VAL_W'(cfg.tip_radius);
        state_next = F_SQ_ER;
      end
      F_SQ_ER: begin
        mul_a      = er;
        mul_b      = er;
        state_next = F_SQ_EZ;
      end
      F_SQ_EZ: begin
        mul_a      = ez;
        mul_b      = ez;
        state_next = F_SUM;
      end
      F_SUM: begin
        state_next = F_ROOT_GO;
      end
      F_ROOT_GO: begin
        sq_start   = 1'b1;
        state_next = F_ROOT_WAIT;
      end
      F_ROOT_WAIT: begin
        if (!sq_busy) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // Capture the cell and everything that needs only an add or a compare.
  always_ff @(posedge clk) begin
    if (accept) begin
      r         <= in_word.radius;
      dz        <= (in_word.height >= cfg.tip_height) ? in_word.height - cfg.tip_height
                                                      : cfg.tip_height - in_word.height;
      below_top <= {1'b0, in_word.height} <= ground_top;
      in_shank  <= (in_word.radius <= cfg.shank_radius) &&
                   (in_word.height >= cfg.tip_height);
      er        <= npr_abs32(in_word.radial_field);
      ez        <= npr_abs32(in_word.axial_field);
      hv_err    <= hv_abs[NPR_VAL_W-1:0];
      gnd_err   <= npr_abs32(in_word.potential);
      last      <= in_word.last_cell;
    end
  end

  // Shared multiplier, one square per cycle; each folds in the next cycle.
  always_ff @(posedge clk) begin
    prod <= NPR_RAD_W'(mul_a) * NPR_RAD_W'(mul_b);
    unique case (state)
      F_SQ_DZ: begin
        sph <= NPR_SPH_W'(prod[2*NPR_COORD_W-1:0]);
      end
      F_SQ_TR: begin
        sph <= sph + NPR_SPH_W'(prod[2*NPR_COORD_W-1:0]);
      end
      F_SQ_ER: begin
        if (below_top) begin
          cls <= CLASS_GROUND;
        end else if (sph <= NPR_SPH_W'(prod[2*NPR_COORD_W-1:0]) || in_shank) begin
          cls <= CLASS_HV;
        end else begin
          cls <= CLASS_GAS;
        end
      end
      F_SQ_EZ: begin
        fsq <= prod;
      end
      F_SUM: begin
        fsq <= fsq + prod;
      end
      F_ROOT_WAIT: begin
        mag <= sq_root;
      end
      default: begin
      end
    endcase
  end

  assign q_task = '{cls: cls, mag: mag, hv_err: hv_err, gnd_err: gnd_err, last: last};

  `ASSERT_IMPLIES(a_root_start_idle, clk, rst, sq_start, !sq_busy)

endmodule

@@ sv/npr_back.sv @@
`include "assert_macros.svh"

module npr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  npr_pkg::npr_task_t q_task,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output npr_pkg::npr_out_t  out_word
);
  import npr_pkg::*;

  logic [NPR_VAL_W-1:0] field_peak;
  logic [NPR_VAL_W-1:0] hv_peak;
  logic [NPR_VAL_W-1:0] gnd_peak;
  logic [NPR_VAL_W-1:0] field_peak_next;
  logic [NPR_VAL_W-1:0] hv_peak_next;
  logic [NPR_VAL_W-1:0] gnd_peak_next;
  logic                 load;

  // Take a word whenever the output register is free or being emptied.
  assign load  = !q_empty && (!out_valid || !out_stall);
  assign q_pop = load;

  always_comb begin
    field_peak_next = (q_task.mag > field_peak) ? q_task.mag : field_peak;
    hv_peak_next    = hv_peak;
    gnd_peak_next   = gnd_peak;
    if (q_task.cls == CLASS_HV && q_task.hv_err > hv_peak) begin
      hv_peak_next = q_task.hv_err;
    end
    if (q_task.cls == CLASS_GROUND && q_task.gnd_err > gnd_peak) begin
      gnd_peak_next = q_task.gnd_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      field_peak <= '0;
      hv_peak    <= '0;
      gnd_peak   <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      // Drop the maxima once the last cell of a sweep is reported.
      if (q_task.last) begin
        field_peak <= '0;
        hv_peak    <= '0;
        gnd_peak   <= '0;
      end else begin
        field_peak <= field_peak_next;
        hv_peak    <= hv_peak_next;
        gnd_peak   <= gnd_peak_next;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= '{cell_class:        q_task.cls,
                    peak_field:        field_peak_next,
                    peak_hv_error:     hv_peak_next,
                    peak_ground_error: gnd_peak_next,
                    sweep_done:        q_task.last};
    end
  end

  `ASSERT_NEXT(a_clear_after_last, clk, rst, load && q_task.last,
    field_peak == '0 && hv_peak == '0 && gnd_peak == '0)

endmodule

@@ sv/needle_plane_cell_residual_reducer.sv @@
// Channel  | Signals                               | Handshake
// ---------+---------------------------------------+---------------------------------
// in       | in_valid, in_stall, in_word           | word taken when valid && !stall
// out      | out_valid, out_stall, out_word        | word taken when valid && !stall
// cfg      | cfg_valid, cfg_ready, cfg_index/data  | write when valid && ready
//
// Per cell, the front runs five squares through one shared 32x32 multiplier,
//   a sum, then a 32-step bit-serial square root.
// A two-word queue parts front and back, so the front keeps working while an
//   output word waits on out_stall; in_stall stays high while the front is busy.
// Reset: rst is synchronous, active high; it loads the register defaults and clears
//   the maxima, the queue and out_valid. cfg_ready is always high; write only when idle.
module needle_plane_cell_residual_reducer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  npr_pkg::npr_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output npr_pkg::npr_out_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import npr_pkg::*;

  npr_cfg_t  cfg;
  npr_task_t push_task;
  npr_task_t pop_task;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  // Register file: one write per handshake, unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ground_height   <= NPR_RST_GROUND_HEIGHT;
      cfg.ground_depth    <= NPR_RST_GROUND_DEPTH;
      cfg.tip_height      <= NPR_RST_TIP_HEIGHT;
      cfg.tip_radius      <= NPR_RST_TIP_RADIUS;
      cfg.shank_radius    <= NPR_RST_SHANK_RADIUS;
      cfg.applied_voltage <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (npr_reg_e'(cfg_index))
        REG_GROUND_HEIGHT:   cfg.ground_height   <= cfg_data[NPR_COORD_W-1:0];
        REG_GROUND_DEPTH:    cfg.ground_depth    <= cfg_data[NPR_COORD_W-1:0];
        REG_TIP_HEIGHT:      cfg.tip_height      <= cfg_data[NPR_COORD_W-1:0];
        REG_TIP_RADIUS:      cfg.tip_radius      <= cfg_data[NPR_COORD_W-1:0];
        REG_SHANK_RADIUS:    cfg.shank_radius    <= cfg_data[NPR_COORD_W-1:0];
        REG_APPLIED_VOLTAGE: cfg.applied_voltage <= cfg_data[NPR_VOLT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept a cell, classify it and take the field magnitude.
  npr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_task   (push_task)
  );

  // Hold classified cells until the back can take them.
  npr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_task (push_task),
    .full      (q_full),
    .pop       (q_pop),
    .pop_task  (pop_task),
    .empty     (q_empty)
  );

  // Back: advance the running maxima and present the result word.
  npr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_task    (pop_task),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
